/* rtl/assert_macros.svh */
// Assertion macros used by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XCFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("xcfr same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define XCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("xcfr next-cycle check failed");

`endif

/* rtl/xcfr_pkg.sv */
// Package with the types, codes and constants of the frame receiver.
package xcfr_pkg;

  localparam int unsigned POS_W = 17;

  typedef logic [7:0]       byte_t;
  typedef logic [15:0]      len_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [2:0]       event_kind_t;
  typedef logic [7:0]       cfg_index_t;
  typedef logic [15:0]      cfg_data_t;

  // Event codes carried on the result channel.
  localparam event_kind_t EV_IGNORED   = 3'd0;
  localparam event_kind_t EV_HEADER    = 3'd1;
  localparam event_kind_t EV_BODY      = 3'd2;
  localparam event_kind_t EV_GOOD      = 3'd3;
  localparam event_kind_t EV_CKSUM_ERR = 3'd4;
  localparam event_kind_t EV_TOO_LONG  = 3'd5;
  localparam event_kind_t EV_BAD_TOKEN = 3'd6;

  // Configuration register indexes.
  localparam cfg_index_t REG_START_MARKER = 8'd0;
  localparam cfg_index_t REG_TOKEN_MARKER = 8'd1;
  localparam cfg_index_t REG_MAX_BODY_LEN = 8'd2;

  // Reset values of the configuration registers.
  localparam byte_t START_MARKER_RST = 8'd27;
  localparam byte_t TOKEN_MARKER_RST = 8'd14;
  localparam len_t  MAX_BODY_LEN_RST = 16'd275;

  // Frame offsets of the header bytes.
  localparam pos_t POS_HUNT   = 17'd0;
  localparam pos_t POS_SEQ    = 17'd1;
  localparam pos_t POS_LEN_HI = 17'd2;
  localparam pos_t POS_LEN_LO = 17'd3;
  localparam pos_t POS_TOKEN  = 17'd4;
  localparam pos_t HDR_BYTES  = 17'd5;

endpackage

/* rtl/xcfr_in_if.sv */
// Input byte channel interface.
interface xcfr_in_if;
  logic           valid;
  logic           ready;
  xcfr_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/xcfr_out_if.sv */
// Result channel interface.
interface xcfr_out_if;
  logic                  valid;
  logic                  ready;
  xcfr_pkg::event_kind_t event_kind;
  xcfr_pkg::byte_t       data_byte;
  xcfr_pkg::len_t        body_index;
  xcfr_pkg::byte_t       sequence_number;
  xcfr_pkg::len_t        body_length;
  logic                  frame_end;

  modport source (output valid, output event_kind, output data_byte, output body_index,
                  output sequence_number, output body_length, output frame_end,
                  input ready);
  modport sink   (input valid, input event_kind, input data_byte, input body_index,
                  input sequence_number, input body_length, input frame_end,
                  output ready);
endinterface

/* rtl/xcfr_cfg_if.sv */
// Configuration write channel interface.
interface xcfr_cfg_if;
  logic                 valid;
  logic                 ready;
  xcfr_pkg::cfg_index_t index;
  xcfr_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/xor_checked_frame_receiver.sv */
// Top level of the XOR-checked frame receiver.
//
//   channel  direction  payload
//   in_ch    sink       rx_byte
//   out_ch   source     event_kind, data_byte, body_index, sequence_number,
//                       body_length, frame_end
//   cfg_ch   sink       index, data (register write)
//
// Every input transaction yields exactly one result transaction, through the result register.
// A new byte is taken in every cycle while the result register is empty or drains
// in that same cycle; the single output register sets that rate of one per cycle.
// Reset (rst_n low, synchronous) empties the result register, restarts the hunt
// for a start marker and restores the configuration registers to their defaults.
// A stalled output holds its result and stops intake until it is taken.
`include "assert_macros.svh"

module xor_checked_frame_receiver (
  input logic       clk,
  input logic       rst_n,
  xcfr_in_if.sink   in_ch,
  xcfr_out_if.source out_ch,
  xcfr_cfg_if.sink  cfg_ch
);

  // Configuration registers.
  xcfr_pkg::byte_t start_marker_r;
  xcfr_pkg::byte_t token_marker_r;
  xcfr_pkg::len_t  max_body_len_r;

  // Frame tracking state.
  xcfr_pkg::pos_t  pos_r, pos_nxt;
  xcfr_pkg::len_t  body_len_r, body_len_nxt;
  xcfr_pkg::byte_t len_hi_r, len_hi_nxt;
  xcfr_pkg::byte_t seq_r, seq_nxt;
  xcfr_pkg::byte_t xor_r, xor_nxt;

  // Result register.
  logic                  out_valid_r;
  xcfr_pkg::event_kind_t out_kind_r, out_kind_nxt;
  xcfr_pkg::byte_t       out_data_r;
  xcfr_pkg::len_t        out_index_r, out_index_nxt;
  xcfr_pkg::byte_t       out_seq_r, out_seq_nxt;
  xcfr_pkg::len_t        out_len_r, out_len_nxt;
  logic                  out_end_r, out_end_nxt;

  logic in_fire;
  logic out_fire;

  // The result register may be refilled in the same cycle it is drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= xcfr_pkg::START_MARKER_RST;
      token_marker_r <= xcfr_pkg::TOKEN_MARKER_RST;
      max_body_len_r <= xcfr_pkg::MAX_BODY_LEN_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        xcfr_pkg::REG_START_MARKER: start_marker_r <= cfg_ch.data[7:0];
        xcfr_pkg::REG_TOKEN_MARKER: token_marker_r <= cfg_ch.data[7:0];
        xcfr_pkg::REG_MAX_BODY_LEN: max_body_len_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Next-state and result logic for the byte on the input channel. The state
  // is the frame offset of the next byte; offset zero means we are hunting.
  always_comb begin
    xcfr_pkg::byte_t b;
    xcfr_pkg::len_t  blen;
    xcfr_pkg::pos_t  last_pos;
    b        = in_ch.rx_byte;
    blen     = {len_hi_r, b};
    // The checksum byte sits at offset body length plus five.
    last_pos = {1'b0, body_len_r} + xcfr_pkg::HDR_BYTES;

    pos_nxt       = pos_r;
    body_len_nxt  = body_len_r;
    len_hi_nxt    = len_hi_r;
    seq_nxt       = seq_r;
    xor_nxt       = xor_r ^ b;
    out_kind_nxt  = xcfr_pkg::EV_IGNORED;
    out_index_nxt = '0;
    out_seq_nxt   = seq_r;
    out_len_nxt   = body_len_r;
    out_end_nxt   = 1'b0;

    if (pos_r == xcfr_pkg::POS_HUNT) begin
      out_seq_nxt = '0;
      out_len_nxt = '0;
      xor_nxt     = xor_r;
      if (b == start_marker_r) begin
        out_kind_nxt = xcfr_pkg::EV_HEADER;
        xor_nxt      = b;
        seq_nxt      = '0;
        len_hi_nxt   = '0;
        body_len_nxt = '0;
        pos_nxt      = xcfr_pkg::POS_SEQ;
      end
    end else if (pos_r == xcfr_pkg::POS_SEQ) begin
      out_kind_nxt = xcfr_pkg::EV_HEADER;
      seq_nxt      = b;
      out_seq_nxt  = b;
      out_len_nxt  = '0;
      pos_nxt      = xcfr_pkg::POS_LEN_HI;
    end else if (pos_r == xcfr_pkg::POS_LEN_HI) begin
      out_kind_nxt = xcfr_pkg::EV_HEADER;
      len_hi_nxt   = b;
      out_len_nxt  = '0;
      pos_nxt      = xcfr_pkg::POS_LEN_LO;
    end else if (pos_r == xcfr_pkg::POS_LEN_LO) begin
      out_len_nxt = blen;
      if (blen > max_body_len_r) begin
        out_kind_nxt = xcfr_pkg::EV_TOO_LONG;
        out_end_nxt  = 1'b1;
        pos_nxt      = xcfr_pkg::POS_HUNT;
      end else begin
        out_kind_nxt = xcfr_pkg::EV_HEADER;
        body_len_nxt = blen;
        pos_nxt      = xcfr_pkg::POS_TOKEN;
      end
    end else if (pos_r == xcfr_pkg::POS_TOKEN) begin
      if (b != token_marker_r) begin
        out_kind_nxt = xcfr_pkg::EV_BAD_TOKEN;
        out_end_nxt  = 1'b1;
        pos_nxt      = xcfr_pkg::POS_HUNT;
      end else begin
        out_kind_nxt = xcfr_pkg::EV_HEADER;
        pos_nxt      = xcfr_pkg::HDR_BYTES;
      end
    end else if (pos_r < last_pos) begin
      out_kind_nxt  = xcfr_pkg::EV_BODY;
      out_index_nxt = 16'(pos_r - xcfr_pkg::HDR_BYTES);
      pos_nxt       = pos_r + 17'd1;
    end else begin
      // Checksum byte: the XOR over the whole frame must come out zero.
      out_kind_nxt = (xor_nxt == 8'd0) ? xcfr_pkg::EV_GOOD : xcfr_pkg::EV_CKSUM_ERR;
      out_end_nxt  = 1'b1;
      pos_nxt      = xcfr_pkg::POS_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= xcfr_pkg::POS_HUNT;
      body_len_r  <= '0;
      len_hi_r    <= '0;
      seq_r       <= '0;
      xor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_r      <= pos_nxt;
        body_len_r <= body_len_nxt;
        len_hi_r   <= len_hi_nxt;
        seq_r      <= seq_nxt;
        xor_r      <= xor_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; only loaded when a transaction is taken.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_kind_r  <= out_kind_nxt;
      out_data_r  <= in_ch.rx_byte;
      out_index_r <= out_index_nxt;
      out_seq_r   <= out_seq_nxt;
      out_len_r   <= out_len_nxt;
      out_end_r   <= out_end_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.event_kind      = out_kind_r;
  assign out_ch.data_byte       = out_data_r;
  assign out_ch.body_index      = out_index_r;
  assign out_ch.sequence_number = out_seq_r;
  assign out_ch.body_length     = out_len_r;
  assign out_ch.frame_end       = out_end_r;

  // A frame-closing result goes with exactly the verdict event codes.
  `XCFR_ASSERT_NOW(a_end_matches_kind, clk, rst_n, out_valid_r,
    out_end_r == (out_kind_r == xcfr_pkg::EV_GOOD || out_kind_r == xcfr_pkg::EV_CKSUM_ERR ||
                  out_kind_r == xcfr_pkg::EV_TOO_LONG || out_kind_r == xcfr_pkg::EV_BAD_TOKEN))

  // Inside the body the offset never passes the checksum byte.
  `XCFR_ASSERT_NOW(a_pos_in_frame, clk, rst_n, pos_r > xcfr_pkg::HDR_BYTES,
    pos_r <= ({1'b0, body_len_r} + xcfr_pkg::HDR_BYTES))

  // A verdict sends the receiver back to hunting.
  `XCFR_ASSERT_NEXT(a_verdict_resets_hunt, clk, rst_n, in_fire && out_end_nxt,
    pos_r == xcfr_pkg::POS_HUNT && out_end_r)

  // While hunting, anything but the start marker is reported as ignored.
  `XCFR_ASSERT_NEXT(a_hunt_ignores, clk, rst_n,
    in_fire && pos_r == xcfr_pkg::POS_HUNT && in_ch.rx_byte != start_marker_r,
    out_valid_r && out_kind_r == xcfr_pkg::EV_IGNORED && pos_r == xcfr_pkg::POS_HUNT)

endmodule
